// ----- hdl/vertex_transform_4x4_macros.svh -----
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

// clocked check, off while aresetn is low
`define VT4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check, active during reset too
`define VT4_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/vt4_pkg.sv -----
`timescale 1ns / 1ps

package vt4_pkg;

    localparam int DIM       = 4;
    localparam int ENTRIES   = DIM * DIM;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W - FRAC_W + 2;
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = DIM * WORD_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [DIM-1:0][WORD_W-1:0] vec_t;

    typedef struct packed {
        logic valid;
        logic en;
    } stage_ctl_t;

endpackage

// ----- hdl/vertex_transform_4x4.sv -----
`timescale 1ns / 1ps
// 4x4 matrix times vector engine, signed Q16.16.
// Input channel s_*: s_tuser[0] selects the operation. A write transfer
// (tuser 0) stores elem_value at elem_index (column*4+row) and returns
// nothing. A transform transfer (tuser 1) returns one m_* transfer holding
// the matrix times (x, y, z, w): products floor-shifted, row sums saturated.
// A transform sees every write accepted before it.
// Path: the result passes the product register, the sum/saturate register
// and the output register before it shows on m_*; the first loads at the
// input transfer edge.
// Throughput: one transfer per cycle while the skid register is empty; four
// lanes, one per matrix row, each with four 32x32 multipliers, work on every vector.
// Reset clears the matrix to zero, empties the pipeline and output stage.
// When m_tready is low the output register holds and a skid register
// takes one more result; s_tready drops while that skid register is full,
// which stalls the whole pipeline. s_tready is driven from a register.

module vertex_transform_4x4 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // elem_index[3:0], elem_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero fill [167:164]
    input  logic [vt4_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [vt4_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + vt4_pkg::IDX_W;
    localparam int VEC_LSB = VAL_LSB + vt4_pkg::WORD_W;

    vt4_pkg::word_t      matrix_reg [vt4_pkg::ENTRIES];
    logic                p1_valid_reg;
    logic                p2_valid_reg;
    logic                en;
    logic                skid_full;
    logic                accept;
    logic [vt4_pkg::IDX_W-1:0] elem_index;
    vt4_pkg::word_t      elem_value;
    vt4_pkg::vec_t       vec;
    vt4_pkg::vec_t       lanes;
    vt4_pkg::stage_ctl_t out_ctl;

    assign en         = !skid_full;
    assign s_tready   = en;
    assign accept     = s_tvalid && s_tready;
    assign elem_index = s_tdata[IDX_LSB +: vt4_pkg::IDX_W];
    assign elem_value = s_tdata[VAL_LSB +: vt4_pkg::WORD_W];
    assign vec        = s_tdata[VEC_LSB +: vt4_pkg::M_TDATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vt4_pkg::ENTRIES; i++) begin
                matrix_reg[i] <= '0;
            end
        end else if (accept && s_tuser[0] == vt4_pkg::OP_WRITE) begin
            matrix_reg[elem_index] <= elem_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= accept && s_tuser[0] == vt4_pkg::OP_XFORM;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    for (genvar r = 0; r < vt4_pkg::DIM; r++) begin : g_lane
        vt4_pkg::vec_t  mat_row;
        vt4_pkg::word_t result;

        for (genvar c = 0; c < vt4_pkg::DIM; c++) begin : g_col
            assign mat_row[c] = matrix_reg[c * vt4_pkg::DIM + r];
        end

        vt4_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .mat_row (mat_row),
            .vec     (vec),
            .result  (result)
        );

        assign lanes[r] = result;
    end

    assign out_ctl.valid = p2_valid_reg;
    assign out_ctl.en    = en;

    vt4_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (out_ctl),
        .lanes     (lanes),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .skid_full (skid_full)
    );

endmodule

// ----- hdl/vt4_lane.sv -----
`timescale 1ns / 1ps

module vt4_lane (
    input  logic          aclk,
    input  logic          en,
    input  vt4_pkg::vec_t mat_row,
    input  vt4_pkg::vec_t vec,
    output vt4_pkg::word_t result
);

    logic signed [vt4_pkg::PROD_W-1:0] prod_reg [vt4_pkg::DIM];
    logic signed [vt4_pkg::SUM_W-1:0]  sum;
    logic [vt4_pkg::SUM_W-vt4_pkg::WORD_W:0] sum_hi;
    vt4_pkg::word_t result_reg;
    vt4_pkg::word_t result_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < vt4_pkg::DIM; c++) begin
                prod_reg[c] <= $signed(mat_row[c]) * $signed(vec[c]);
            end
        end
    end

    // floor shift per product, exact sum, then clamp to 32 bits
    always_comb begin
        sum = '0;
        for (int c = 0; c < vt4_pkg::DIM; c++) begin
            sum = sum + vt4_pkg::SUM_W'(prod_reg[c] >>> vt4_pkg::FRAC_W);
        end
        sum_hi = sum[vt4_pkg::SUM_W-1:vt4_pkg::WORD_W-1];
        if ((&sum_hi) || !(|sum_hi)) begin
            result_next = sum[vt4_pkg::WORD_W-1:0];
        end else if (sum[vt4_pkg::SUM_W-1]) begin
            result_next = {1'b1, {(vt4_pkg::WORD_W-1){1'b0}}};
        end else begin
            result_next = {1'b0, {(vt4_pkg::WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- hdl/vt4_out.sv -----
`timescale 1ns / 1ps

module vt4_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vt4_pkg::stage_ctl_t           ctl,
    input  vt4_pkg::vec_t                 lanes,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [vt4_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          skid_full
);

    logic                          out_valid_reg;
    logic [vt4_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                          sk_valid_reg;
    logic [vt4_pkg::M_TDATA_W-1:0] sk_data_reg;
    logic                          in_valid;
    logic [vt4_pkg::M_TDATA_W-1:0] in_data;

    assign in_valid = ctl.valid && ctl.en;
    assign in_data  = lanes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end else if (sk_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= sk_data_reg;
                sk_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg  <= in_data;
                out_valid_reg <= 1'b1;
            end else begin
                sk_data_reg  <= in_data;
                sk_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign skid_full = sk_valid_reg;

endmodule

// ----- hdl/vt4_checker.sv -----
`timescale 1ns / 1ps
`include "vertex_transform_4x4_macros.svh"

module vt4_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vt4_pkg::M_TDATA_W-1:0] m_tdata
);

    // output stage comes out of reset empty
    `VT4_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // a stalled result keeps its data
    `VT4_ASSERT(a_hold_data, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // input stalls only when a result is waiting at the output
    `VT4_ASSERT(a_stall_has_result, !s_tready |-> m_tvalid, "s_tready low with empty output")

    // a full skid stage stays full until the output moves
    `VT4_ASSERT(a_skid_holds, (!s_tready && !m_tready) |=> !s_tready, "skid drained without transfer")

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);
